FILE: rtl/brightness_to_alpha_interpolator_unit_assert.svh
// Assertion macros for the brightness to alpha interpolator.
`ifndef BRIGHTNESS_TO_ALPHA_INTERPOLATOR_UNIT_ASSERT_SVH
`define BRIGHTNESS_TO_ALPHA_INTERPOLATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high.
`define B2A_ASSERT_SAME(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("b2a assertion failed");
// Next-cycle implication, disabled while reset is high.
`define B2A_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("b2a assertion failed");
`else
`define B2A_ASSERT_SAME(label, clk, rst, lhs, rhs)
`define B2A_ASSERT_NEXT(label, clk, rst, lhs, rhs)
`endif

`endif

FILE: rtl/b2a_pkg.sv
// Types, breakpoint tables and constants of the brightness to alpha interpolator.
package b2a_pkg;

   localparam int FIELD_W   = 12;
   localparam int LEVELS_A  = 20;
   localparam int LEVELS_B  = 23;
   localparam int IDX_W     = 5;   // segment index 0 .. LEVELS_B
   localparam int DY_W      = 7;   // largest alpha drop across one segment is 80
   localparam int PROD_W    = 14;  // dy * dx stays below 80 * 164
   localparam int RCP_SHIFT = 22;  // PROD_W plus eight bits for divisors up to 164
   localparam int RCP_W     = RCP_SHIFT + 1;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_SELECT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERRIDE     = 1'd1;

   localparam logic [FIELD_W-1:0] LEVEL_A [LEVELS_A] = '{
      12'd0,   12'd1,   12'd165, 12'd195, 12'd235, 12'd305, 12'd400,
      12'd500, 12'd580, 12'd591, 12'd660, 12'd720, 12'd780, 12'd825,
      12'd865, 12'd900, 12'd963, 12'd1000, 12'd1050, 12'd1100
   };
   localparam logic [FIELD_W-1:0] VALUE_A [LEVELS_A] = '{
      12'd1020, 12'd1020, 12'd1001, 12'd993, 12'd980, 12'd960, 12'd920,
      12'd880,  12'd840,  12'd800,  12'd720, 12'd640, 12'd560, 12'd480,
      12'd400,  12'd320,  12'd240,  12'd160, 12'd80,  12'd0
   };
   localparam logic [FIELD_W-1:0] LEVEL_B [LEVELS_B] = '{
      12'd0,   12'd1,   12'd2,   12'd3,   12'd4,   12'd5,   12'd6,   12'd8,
      12'd10,  12'd15,  12'd20,  12'd30,  12'd45,  12'd70,  12'd100, 12'd120,
      12'd140, 12'd160, 12'd180, 12'd200, 12'd220, 12'd240, 12'd260
   };
   localparam logic [FIELD_W-1:0] VALUE_B [LEVELS_B] = '{
      12'hff, 12'hfc, 12'hfb, 12'hfa, 12'hf9, 12'hf8, 12'hf7, 12'hf6,
      12'hf4, 12'hf0, 12'hea, 12'he0, 12'hd0, 12'hbc, 12'h98, 12'h80,
      12'h70, 12'h58, 12'h48, 12'h30, 12'h20, 12'h10, 12'h00
   };

   // One interpolation segment: alpha = ya - dy * (x - xa) * rcp >> RCP_SHIFT.
   typedef struct packed {
      logic [FIELD_W-1:0] xa;
      logic [FIELD_W-1:0] ya;
      logic [DY_W-1:0]    dy;
      logic [RCP_W-1:0]   rcp;
   } seg_type;

endpackage

FILE: rtl/b2a_req_if.sv
// Request channel carrying one brightness item.
interface b2a_req_if;
   logic                          valid;
   logic                          ready;
   logic [b2a_pkg::FIELD_W-1:0]   brightness;

   modport source (output valid, output brightness, input ready);
   modport sink   (input valid, input brightness, output ready);
endinterface

FILE: rtl/b2a_rsp_if.sv
// Response channel carrying one alpha item.
interface b2a_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [b2a_pkg::FIELD_W-1:0]   alpha;

   modport source (output valid, output alpha, input ready);
   modport sink   (input valid, input alpha, output ready);
endinterface

FILE: rtl/b2a_seg_lut.sv
// Segment constant table: start point, start alpha, drop and divisor reciprocal.
module b2a_seg_lut (
   input  logic                          tsel,
   input  logic [b2a_pkg::IDX_W-1:0]     idx,
   output b2a_pkg::seg_type              seg
);

   b2a_pkg::seg_type seg_a [b2a_pkg::LEVELS_A+1];
   b2a_pkg::seg_type seg_b [b2a_pkg::LEVELS_B+1];

   // Segment 0 is the flat part at the first breakpoint, the last one the flat tail.
   for (genvar k = 0; k <= b2a_pkg::LEVELS_A; k++) begin : g_seg_a
      if (k == 0) begin : g_first
         assign seg_a[k] = '{xa: '0, ya: b2a_pkg::VALUE_A[0], dy: '0, rcp: '0};
      end else if (k == b2a_pkg::LEVELS_A) begin : g_last
         assign seg_a[k] = '{xa: b2a_pkg::LEVEL_A[k-1], ya: b2a_pkg::VALUE_A[k-1],
                             dy: '0, rcp: '0};
      end else begin : g_mid
         localparam int Den = int'(b2a_pkg::LEVEL_A[k]) - int'(b2a_pkg::LEVEL_A[k-1]);
         localparam int Rcp = ((1 << b2a_pkg::RCP_SHIFT) + Den - 1) / Den;
         assign seg_a[k] = '{xa: b2a_pkg::LEVEL_A[k-1], ya: b2a_pkg::VALUE_A[k-1],
                             dy: b2a_pkg::DY_W'(b2a_pkg::VALUE_A[k-1] - b2a_pkg::VALUE_A[k]),
                             rcp: b2a_pkg::RCP_W'(Rcp)};
      end
   end

   for (genvar k = 0; k <= b2a_pkg::LEVELS_B; k++) begin : g_seg_b
      if (k == 0) begin : g_first
         assign seg_b[k] = '{xa: '0, ya: b2a_pkg::VALUE_B[0], dy: '0, rcp: '0};
      end else if (k == b2a_pkg::LEVELS_B) begin : g_last
         assign seg_b[k] = '{xa: b2a_pkg::LEVEL_B[k-1], ya: b2a_pkg::VALUE_B[k-1],
                             dy: '0, rcp: '0};
      end else begin : g_mid
         localparam int Den = int'(b2a_pkg::LEVEL_B[k]) - int'(b2a_pkg::LEVEL_B[k-1]);
         localparam int Rcp = ((1 << b2a_pkg::RCP_SHIFT) + Den - 1) / Den;
         assign seg_b[k] = '{xa: b2a_pkg::LEVEL_B[k-1], ya: b2a_pkg::VALUE_B[k-1],
                             dy: b2a_pkg::DY_W'(b2a_pkg::VALUE_B[k-1] - b2a_pkg::VALUE_B[k]),
                             rcp: b2a_pkg::RCP_W'(Rcp)};
      end
   end

   always_comb begin
      seg = seg_a[0];
      if (tsel) begin
         if (idx <= b2a_pkg::IDX_W'(b2a_pkg::LEVELS_B)) begin
            seg = seg_b[idx];
         end
      end else begin
         if (idx <= b2a_pkg::IDX_W'(b2a_pkg::LEVELS_A)) begin
            seg = seg_a[idx];
         end
      end
   end

endmodule

FILE: rtl/brightness_to_alpha_interpolator_unit.sv
// Top level of the brightness to dimming-layer alpha interpolator.
//
// Converts a 12-bit backlight brightness into a 12-bit dimming-layer alpha by
// piecewise linear interpolation over one of two constant breakpoint tables
// (20 entries when table_select is 0, 23 when it is 1). A nonzero
// override_alpha replaces every result. The datapath is a five-register
// pipeline: breakpoint compare, segment table read, dy * dx multiply,
// reciprocal multiply for the truncating divide, then final subtract and
// override select into the output register. One item is taken per cycle while
// rsp_bus accepts; each result passes through all five registers before it is
// offered on rsp_bus. Each stage holds its item while the next is full, so a
// stall on the response side fills the bubbles first and only then stops
// req_bus.ready. Registers are written through csr_we / csr_index / csr_wdata
// and must only be changed while no item is in flight.

`include "brightness_to_alpha_interpolator_unit_assert.svh"

module brightness_to_alpha_interpolator_unit (
   input  logic                              clock,
   input  logic                              reset,
   b2a_req_if.sink                           req_bus,
   b2a_rsp_if.source                         rsp_bus,
   input  logic                              csr_we,
   input  logic [b2a_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [b2a_pkg::FIELD_W-1:0]       csr_wdata
);

   // configuration registers
   logic                          tsel_ff;
   logic [b2a_pkg::FIELD_W-1:0]   ovr_ff;

   // stage 1: segment index
   logic                          v1_ff;
   logic [b2a_pkg::FIELD_W-1:0]   x1_ff;
   logic [b2a_pkg::IDX_W-1:0]     idx1_ff, idx1_in;

   // stage 2: segment constants
   logic                          v2_ff;
   logic [b2a_pkg::FIELD_W-1:0]   x2_ff;
   b2a_pkg::seg_type              seg2_ff, seg2_in;

   // stage 3: dy * dx product
   logic                          v3_ff;
   logic [b2a_pkg::PROD_W-1:0]    p3_ff, p3_in;
   logic [b2a_pkg::FIELD_W-1:0]   ya3_ff;
   logic [b2a_pkg::RCP_W-1:0]     rcp3_ff;

   // stage 4: quotient
   logic                          v4_ff;
   logic [b2a_pkg::DY_W-1:0]      q4_ff, q4_in;
   logic [b2a_pkg::FIELD_W-1:0]   ya4_ff;

   // output register
   logic                          vo_ff;
   logic [b2a_pkg::FIELD_W-1:0]   alpha_ff, alpha_in;

   logic en1, en2, en3, en4, en_out;
   logic [b2a_pkg::FIELD_W-1:0]          dx;
   logic [b2a_pkg::DY_W+b2a_pkg::FIELD_W-1:0] prod_full;
   logic [b2a_pkg::PROD_W+b2a_pkg::RCP_W-1:0] quot_full;

   // Advance a stage when it is empty or its successor advances.
   assign en_out = !vo_ff || rsp_bus.ready;
   assign en4    = !v4_ff || en_out;
   assign en3    = !v3_ff || en4;
   assign en2    = !v2_ff || en3;
   assign en1    = !v1_ff || en2;

   assign req_bus.ready = en1;
   assign rsp_bus.valid = vo_ff;
   assign rsp_bus.alpha = alpha_ff;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         tsel_ff <= 1'b0;
         ovr_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            b2a_pkg::CSR_TABLE_SELECT: tsel_ff <= csr_wdata[0];
            b2a_pkg::CSR_OVERRIDE:     ovr_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Index of the first breakpoint at or above x: count the breakpoints below it.
   always_comb begin
      idx1_in = '0;
      if (tsel_ff) begin
         for (int i = 0; i < b2a_pkg::LEVELS_B; i++) begin
            if (b2a_pkg::LEVEL_B[i] < req_bus.brightness) begin
               idx1_in = b2a_pkg::IDX_W'(i + 1);
            end
         end
      end else begin
         for (int i = 0; i < b2a_pkg::LEVELS_A; i++) begin
            if (b2a_pkg::LEVEL_A[i] < req_bus.brightness) begin
               idx1_in = b2a_pkg::IDX_W'(i + 1);
            end
         end
      end
   end

   b2a_seg_lut u_seg_lut (
      .tsel (tsel_ff),
      .idx  (idx1_ff),
      .seg  (seg2_in)
   );

   // dx never exceeds the segment width wherever dy is nonzero.
   assign dx        = x2_ff - seg2_ff.xa;
   assign prod_full = seg2_ff.dy * dx;
   assign p3_in     = prod_full[b2a_pkg::PROD_W-1:0];

   // Exact truncating divide by the segment width via its rounded-up reciprocal.
   assign quot_full = p3_ff * rcp3_ff;
   assign q4_in     = quot_full[b2a_pkg::RCP_SHIFT +: b2a_pkg::DY_W];

   assign alpha_in  = (ovr_ff != '0) ? ovr_ff
                    : ya4_ff - {{(b2a_pkg::FIELD_W-b2a_pkg::DY_W){1'b0}}, q4_ff};

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (en1)    v1_ff <= req_bus.valid;
         if (en2)    v2_ff <= v1_ff;
         if (en3)    v3_ff <= v2_ff;
         if (en4)    v4_ff <= v3_ff;
         if (en_out) vo_ff <= v4_ff;
      end
   end

   // Payload: hold while the stage is stalled.
   always_ff @(posedge clock) begin
      if (en1) begin
         x1_ff   <= req_bus.brightness;
         idx1_ff <= idx1_in;
      end
      if (en2) begin
         x2_ff   <= x1_ff;
         seg2_ff <= seg2_in;
      end
      if (en3) begin
         p3_ff   <= p3_in;
         ya3_ff  <= seg2_ff.ya;
         rcp3_ff <= seg2_ff.rcp;
      end
      if (en4) begin
         q4_ff   <= q4_in;
         ya4_ff  <= ya3_ff;
      end
      if (en_out) begin
         alpha_ff <= alpha_in;
      end
   end

   // An accepted item lands in stage 1.
   `B2A_ASSERT_NEXT(a_accept_fills_s1, clock, reset, req_bus.valid && req_bus.ready, v1_ff)
   // The interpolated drop never exceeds the segment's start alpha.
   `B2A_ASSERT_SAME(a_quot_in_range, clock, reset, v4_ff,
                    {{(b2a_pkg::FIELD_W-b2a_pkg::DY_W){1'b0}}, q4_ff} <= ya4_ff)
   // A stalled stage 2 keeps its item.
   `B2A_ASSERT_NEXT(a_s2_holds, clock, reset, v2_ff && !en3, v2_ff && $stable(seg2_ff))

endmodule

FILE: verif/b2a_checker.sv
`timescale 1ns / 100ps
// Scoreboard that predicts each alpha item of the interpolator and checks the responses.
module b2a_checker (
   input  logic                            clock,
   input  logic                            reset,
   b2a_req_if                              req_mon,
   b2a_rsp_if                              rsp_mon,
   input  logic                            csr_we,
   input  logic [b2a_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [b2a_pkg::FIELD_W-1:0]     csr_wdata,
   output int                              outstanding,
   output int                              fail_count
);

   // breakpoints of the two dimming curves: brightness level and alpha
   int dim_a_level [20] = '{0, 1, 165, 195, 235, 305, 400, 500, 580, 591,
                            660, 720, 780, 825, 865, 900, 963, 1000, 1050, 1100};
   int dim_a_alpha [20] = '{1020, 1020, 1001, 993, 980, 960, 920, 880, 840, 800,
                            720, 640, 560, 480, 400, 320, 240, 160, 80, 0};
   int dim_b_level [23] = '{0, 1, 2, 3, 4, 5, 6, 8, 10, 15, 20, 30, 45, 70, 100,
                            120, 140, 160, 180, 200, 220, 240, 260};
   int dim_b_alpha [23] = '{'hff, 'hfc, 'hfb, 'hfa, 'hf9, 'hf8, 'hf7, 'hf6,
                            'hf4, 'hf0, 'hea, 'he0, 'hd0, 'hbc, 'h98, 'h80,
                            'h70, 'h58, 'h48, 'h30, 'h20, 'h10, 'h00};

   logic                          cfg_table_sel = 1'b0;
   logic [b2a_pkg::FIELD_W-1:0]   cfg_override  = '0;
   logic [b2a_pkg::FIELD_W-1:0]   expected_alpha [$];
   logic [b2a_pkg::FIELD_W-1:0]   oldest_alpha;

   initial fail_count = 0;

   function automatic logic [b2a_pkg::FIELD_W-1:0] alpha_for(
      input logic [b2a_pkg::FIELD_W-1:0] level);
      int n, i, x, xa, xb, ya, yb, a;
      if (cfg_override != '0)
         return cfg_override;
      n = cfg_table_sel ? 23 : 20;
      x = int'(level);
      i = 0;
      while (i < n && (cfg_table_sel ? dim_b_level[i] : dim_a_level[i]) < x)
         i++;
      if (i == 0) begin
         a = cfg_table_sel ? dim_b_alpha[0] : dim_a_alpha[0];
      end else if (i >= n) begin
         a = cfg_table_sel ? dim_b_alpha[n-1] : dim_a_alpha[n-1];
      end else begin
         xa = cfg_table_sel ? dim_b_level[i-1] : dim_a_level[i-1];
         xb = cfg_table_sel ? dim_b_level[i]   : dim_a_level[i];
         ya = cfg_table_sel ? dim_b_alpha[i-1] : dim_a_alpha[i-1];
         yb = cfg_table_sel ? dim_b_alpha[i]   : dim_a_alpha[i];
         // signed division truncates toward zero
         a = ya + ((yb - ya) * (x - xa)) / (xb - xa);
      end
      if (a < 0)
         a = 0;
      if (a > 4095)
         a = 4095;
      return a[b2a_pkg::FIELD_W-1:0];
   endfunction

   task automatic note_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      fail_count = fail_count + 1;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_table_sel <= 1'b0;
         cfg_override  <= '0;
         expected_alpha.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_alpha.size() == 0) begin
               note_mismatch($sformatf("alpha %0d with nothing expected", rsp_mon.alpha));
            end else begin
               oldest_alpha = expected_alpha.pop_front();
               if (rsp_mon.alpha !== oldest_alpha)
                  note_mismatch($sformatf("alpha %0d, expected %0d",
                                          rsp_mon.alpha, oldest_alpha));
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_alpha.push_back(alpha_for(req_mon.brightness));
         if (csr_we) begin
            if (csr_index == b2a_pkg::CSR_TABLE_SELECT)
               cfg_table_sel <= csr_wdata[0];
            else if (csr_index == b2a_pkg::CSR_OVERRIDE)
               cfg_override <= csr_wdata;
         end
      end
      outstanding <= expected_alpha.size();
   end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// Top of the interpolator testbench: clock, reset, stimulus, back-pressure and verdict.
module tb;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           csr_we;
   logic [b2a_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [b2a_pkg::FIELD_W-1:0]    csr_wdata;
   int                             outstanding;
   int                             fail_count;

   // stimulus state shared with the response-side process
   int                    phase_no = -1;
   bit                    calm     = 1'b0;

   b2a_req_if req_bus ();
   b2a_rsp_if rsp_bus ();

   brightness_to_alpha_interpolator_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   b2a_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop for a run that hangs: report mismatches and finish.
   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // Offer one brightness item and hold it until the block takes it. Now and
   // then drop valid first, unless in the calm phase.
   task automatic push_brightness(input logic [b2a_pkg::FIELD_W-1:0] level);
      int gap;
      if (!calm && $urandom_range(0, 99) < 11) begin
         req_bus.valid <= 1'b0;
         gap = $urandom_range(1, 2);
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.brightness <= level;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   // Stop offering items and wait, within a bound, until every alpha item is
   // back, then let the pipeline go quiet.
   task automatic drain_pipeline();
      int waited;
      waited = 0;
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
   endtask

   // Write both registers on consecutive edges. Only ever called when idle.
   // The unused upper bits of the table-select write carry random data.
   task automatic write_settings(input logic sel,
                                 input logic [b2a_pkg::FIELD_W-1:0] override_val);
      csr_we    <= 1'b1;
      csr_index <= b2a_pkg::CSR_TABLE_SELECT;
      csr_wdata <= {11'($urandom), sel};
      @(posedge clock);
      csr_index <= b2a_pkg::CSR_OVERRIDE;
      csr_wdata <= override_val;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Mostly levels in and just past the span of the selected curve, where the
   // interpolation happens; the rest anywhere in the 12-bit range.
   function automatic logic [b2a_pkg::FIELD_W-1:0] pick_brightness(input logic sel);
      if ($urandom_range(0, 99) < 72)
         return sel ? b2a_pkg::FIELD_W'($urandom_range(0, 280))
                    : b2a_pkg::FIELD_W'($urandom_range(0, 1150));
      return b2a_pkg::FIELD_W'($urandom_range(0, 4095));
   endfunction

   // Response side: accept most cycles, refuse about 16 in a hundred. Once,
   // early in phase 4, refuse for a long run so the pipeline fills and stalls
   // the request side while the sender keeps offering items.
   initial begin
      int choke_left;
      bit choke_done;
      choke_left = 0;
      choke_done = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!choke_done && phase_no == 4) begin
            choke_done = 1'b1;
            choke_left = 64;
         end
         if (choke_left > 0) begin
            rsp_bus.ready <= 1'b0;
            choke_left--;
         end else if (calm) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= 16);
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      // hand-picked levels: ends of the range, breakpoints and their neighbours
      logic [b2a_pkg::FIELD_W-1:0] probe_a [13] = '{12'd0, 12'd1, 12'd2, 12'd100, 12'd164,
                                                    12'd165, 12'd590, 12'd591, 12'd1050,
                                                    12'd1099, 12'd1100, 12'd1101, 12'd4095};
      logic [b2a_pkg::FIELD_W-1:0] probe_b [10] = '{12'd0, 12'd1, 12'd6, 12'd7, 12'd8,
                                                    12'd259, 12'd260, 12'd261, 12'd2730,
                                                    12'd4095};
      logic [b2a_pkg::FIELD_W-1:0] probe_ovr [3] = '{12'd0, 12'd4095, 12'd1365};
      logic                        sel;
      logic [b2a_pkg::FIELD_W-1:0] override_val;

      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.brightness <= '0;
      csr_we             <= 1'b0;
      csr_index          <= b2a_pkg::CSR_TABLE_SELECT;
      csr_wdata          <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: first curve, second curve, then the override at its top
      // value, which must win whatever the level
      write_settings(1'b0, 12'd0);
      foreach (probe_a[i]) push_brightness(probe_a[i]);
      drain_pipeline();
      write_settings(1'b1, 12'd0);
      foreach (probe_b[i]) push_brightness(probe_b[i]);
      drain_pipeline();
      write_settings(1'b1, 12'd4095);
      foreach (probe_ovr[i]) push_brightness(probe_ovr[i]);

      // random phases, each under its own settings; phase 1 runs with no
      // idling on either side, phase 4 carries the long response stall
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin sel = 1'b0; override_val = 12'd0; end
            1: begin sel = 1'b1; override_val = 12'd0; end
            2: begin sel = 1'b0; override_val = 12'd4095; end
            3: begin sel = 1'b1; override_val = b2a_pkg::FIELD_W'($urandom_range(1, 4094)); end
            4: begin sel = 1'b0; override_val = 12'd0; end
            5: begin sel = 1'b1; override_val = 12'd0; end
            6: begin sel = 1'($urandom); override_val = 12'd0; end
            default: begin sel = 1'($urandom); override_val = 12'd1; end
         endcase
         drain_pipeline();
         write_settings(sel, override_val);
         calm     = (ph == 1);
         phase_no = ph;
         repeat (172) push_brightness(pick_brightness(sel));
      end
      calm = 1'b0;

      drain_pipeline();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
